// File: rtl/core/arpr_pkg.sv
`timescale 1ns / 1ps

package arpr_pkg;

	localparam int IN_TDATA_W  = 224;
	localparam int OUT_TDATA_W = 160;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 48;

	localparam logic [CFG_IDX_W-1:0] REG_MY_MAC = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MY_IP  = 1'd1;

	localparam logic [47:0] BCAST_MAC   = 48'hFFFF_FFFF_FFFF;
	localparam logic [15:0] ETYPE_ARP   = 16'h0806;
	localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
	localparam logic [15:0] HW_ETHERNET = 16'h0001;
	localparam logic [15:0] ARP_REQ     = 16'h0001;
	localparam logic [15:0] ARP_REP     = 16'h0002;

	localparam logic OP_SEND    = 1'b0;
	localparam logic OP_RECEIVE = 1'b1;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_REQUEST = 3'd1,
		ACT_DATA    = 3'd2,
		ACT_REPLY   = 3'd3,
		ACT_DELIVER = 3'd4
	} action_t;

	typedef struct packed {
		logic [31:0] sender_ip;
		logic [47:0] sender_mac;
		logic [15:0] arp_opcode;
		logic [15:0] proto_type;
		logic [15:0] hw_type;
		logic [47:0] dest_mac;
		logic [15:0] frame_type;
		logic [31:0] target_ip;
	} in_fields_t;

	typedef struct packed {
		logic [31:0] out_target_ip;
		logic [47:0] out_target_mac;
		logic [15:0] out_arp_opcode;
		logic [15:0] out_frame_type;
		logic [47:0] out_dest_mac;
	} out_fields_t;

	typedef struct packed {
		logic        rd_en;
		logic [7:0]  rd_slot;
		logic [7:0]  chk_slot;
		logic        wr_en;
		logic [7:0]  wr_slot;
		logic [47:0] wr_mac;
	} tbl_req_t;

	typedef struct packed {
		logic        rd_known;
		logic        chk_known;
		logic [47:0] rd_mac;
	} tbl_rsp_t;

endpackage

// File: rtl/core/arpr_table.sv
`timescale 1ns / 1ps

module arpr_table #(
	parameter int ENTRIES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  arpr_pkg::tbl_req_t req,
	output arpr_pkg::tbl_rsp_t rsp
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [ENTRIES-1:0] valid_q;
	logic [47:0]        mac_mem [ENTRIES];
	logic [47:0]        rd_mac_q;

	logic             rd_in_range;
	logic             chk_in_range;
	logic             wr_in_range;
	logic [IDX_W-1:0] rd_idx;
	logic [IDX_W-1:0] chk_idx;
	logic [IDX_W-1:0] wr_idx;

	assign rd_in_range  = {1'b0, req.rd_slot}  < 9'(ENTRIES);
	assign chk_in_range = {1'b0, req.chk_slot} < 9'(ENTRIES);
	assign wr_in_range  = {1'b0, req.wr_slot}  < 9'(ENTRIES);

	assign rd_idx  = req.rd_slot[IDX_W-1:0];
	assign chk_idx = req.chk_slot[IDX_W-1:0];
	assign wr_idx  = req.wr_slot[IDX_W-1:0];

	assign rsp.rd_known  = rd_in_range && valid_q[rd_idx];
	assign rsp.chk_known = chk_in_range && valid_q[chk_idx];
	assign rsp.rd_mac    = rd_mac_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.wr_en && wr_in_range) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en && wr_in_range) begin
			mac_mem[wr_idx] <= req.wr_mac;
		end
		if (req.rd_en) begin
			rd_mac_q <= mac_mem[rd_idx];
		end
	end

endmodule

// File: rtl/core/arp_resolver_table.sv
`timescale 1ns / 1ps

// Channel   Direction  tdata                                  tuser
// s_*       in         target_ip, frame_type, dest_mac,        op
//                      hw_type, proto_type, arp_opcode,
//                      sender_mac, sender_ip
// m_*       out        out_dest_mac, out_frame_type,           action
//                      out_arp_opcode, out_target_mac,
//                      out_target_ip
// cfg_*     in         register 0 my_mac, register 1 my_ip
//
// Every word gives exactly one result word; it is registered in stage 1, then in stage 2.
// A new word is accepted each cycle unless both stages are full and m_tready is low;
// the table read and write-back are done in the first stage and the registered table read feeds the second.
// Reset clears the valid bits and the own addresses at once.
// When m_tready is low, a full stage holds and s_tready drops once both stages are full.

module arp_resolver_table #(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// target_ip, frame_type, dest_mac, hw_type, proto_type, arp_opcode,
	// sender_mac, sender_ip
	input  logic [arpr_pkg::IN_TDATA_W-1:0]      s_tdata,
	// op
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// out_dest_mac, out_frame_type, out_arp_opcode, out_target_mac,
	// out_target_ip
	output logic [arpr_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// action
	output logic [2:0]                           m_tuser,
	input  logic                                 cfg_wen,
	input  logic [arpr_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [arpr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	logic [47:0] my_mac_q;
	logic [31:0] my_ip_q;

	logic                 valid_s1;
	logic                 op_s1;
	arpr_pkg::in_fields_t item_s1;

	logic                  valid_s2;
	arpr_pkg::action_t     action_s2;
	arpr_pkg::out_fields_t res_s2;

	arpr_pkg::tbl_req_t tbl_req;
	arpr_pkg::tbl_rsp_t tbl_rsp;

	logic                  load_s2;
	logic                  adv_s1;
	logic                  is_arp;
	logic                  arp_ok;
	logic                  for_us;
	logic                  learn;
	arpr_pkg::action_t     action_d;
	arpr_pkg::out_fields_t res_d;
	arpr_pkg::out_fields_t res_out;

	assign load_s2  = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && load_s2;
	assign s_tready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_mac_q <= '0;
			my_ip_q  <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				arpr_pkg::REG_MY_MAC: my_mac_q <= cfg_wdata;
				arpr_pkg::REG_MY_IP:  my_ip_q  <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= s_tuser;
			item_s1 <= arpr_pkg::in_fields_t'(s_tdata);
		end
		if (adv_s1) begin
			action_s2 <= action_d;
			res_s2    <= res_d;
		end
	end

	assign is_arp = item_s1.frame_type == arpr_pkg::ETYPE_ARP;
	assign arp_ok = is_arp && item_s1.hw_type == arpr_pkg::HW_ETHERNET
		&& item_s1.proto_type == arpr_pkg::ETYPE_IPV4;
	assign for_us = item_s1.target_ip == my_ip_q;
	assign learn  = op_s1 == arpr_pkg::OP_RECEIVE && arp_ok
		&& (tbl_rsp.chk_known || for_us);

	always_comb begin
		action_d = arpr_pkg::ACT_NONE;
		res_d    = '0;
		if (op_s1 == arpr_pkg::OP_SEND) begin
			if (tbl_rsp.rd_known) begin
				action_d             = arpr_pkg::ACT_DATA;
				res_d.out_frame_type = arpr_pkg::ETYPE_IPV4;
			end else begin
				action_d             = arpr_pkg::ACT_REQUEST;
				res_d.out_dest_mac   = arpr_pkg::BCAST_MAC;
				res_d.out_frame_type = arpr_pkg::ETYPE_ARP;
				res_d.out_arp_opcode = arpr_pkg::ARP_REQ;
				res_d.out_target_mac = arpr_pkg::BCAST_MAC;
				res_d.out_target_ip  = item_s1.target_ip;
			end
		end else if (is_arp) begin
			if (arp_ok && for_us && item_s1.arp_opcode == arpr_pkg::ARP_REQ) begin
				action_d             = arpr_pkg::ACT_REPLY;
				res_d.out_dest_mac   = item_s1.sender_mac;
				res_d.out_frame_type = arpr_pkg::ETYPE_ARP;
				res_d.out_arp_opcode = arpr_pkg::ARP_REP;
				res_d.out_target_mac = item_s1.sender_mac;
				res_d.out_target_ip  = item_s1.sender_ip;
			end
		end else if (item_s1.dest_mac == my_mac_q) begin
			action_d = arpr_pkg::ACT_DELIVER;
		end
	end

	always_comb begin
		tbl_req.rd_en    = adv_s1;
		tbl_req.rd_slot  = item_s1.target_ip[7:0];
		tbl_req.chk_slot = item_s1.sender_ip[7:0];
		tbl_req.wr_en    = adv_s1 && learn;
		tbl_req.wr_slot  = item_s1.sender_ip[7:0];
		tbl_req.wr_mac   = item_s1.sender_mac;
	end

	arpr_table #(
		.ENTRIES(TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (tbl_req),
		.rsp   (tbl_rsp)
	);

	always_comb begin
		res_out = res_s2;
		if (action_s2 == arpr_pkg::ACT_DATA) begin
			res_out.out_dest_mac = tbl_rsp.rd_mac;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = res_out;
	assign m_tuser  = action_s2;

endmodule

// File: rtl/core/arpr_checker.sv
`timescale 1ns / 1ps

module arpr_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [arpr_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [2:0]                       m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Stalled result word changed.");

	a_request: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == arpr_pkg::ACT_REQUEST |->
		m_tdata[47:0] == arpr_pkg::BCAST_MAC && m_tdata[127:80] == arpr_pkg::BCAST_MAC
		&& m_tdata[79:64] == arpr_pkg::ARP_REQ)
		else $error("ARP request is not a broadcast request.");

	a_reply: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == arpr_pkg::ACT_REPLY |->
		m_tdata[47:0] == m_tdata[127:80] && m_tdata[79:64] == arpr_pkg::ARP_REP
		&& m_tdata[63:48] == arpr_pkg::ETYPE_ARP)
		else $error("ARP reply fields disagree.");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == arpr_pkg::ACT_NONE || m_tuser == arpr_pkg::ACT_DELIVER)
		|-> m_tdata == '0)
		else $error("Result word without a frame carries data.");

endmodule

bind arp_resolver_table arpr_checker u_arpr_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

// File: tb/arp_resolver_table_checker.sv
`timescale 1ns / 1ps

module arp_resolver_table_checker #(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [arpr_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  logic                              s_tuser,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [arpr_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input  logic [2:0]                        m_tuser,
	input  logic                              cfg_wen,
	input  logic [arpr_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [arpr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output int                                mismatches,
	output int                                replies_owed
);

	import arpr_pkg::*;

	typedef struct {
		action_t     act;
		out_fields_t fields;
	} reply_t;

	logic [47:0] own_mac = '0;
	logic [31:0] own_ip  = '0;
	logic [47:0] learned_mac [256];
	bit          learned     [256];
	reply_t      replies_due [$];

	initial begin
		mismatches   = 0;
		replies_owed = 0;
		foreach (learned[i])
			learned[i] = 1'b0;
	end

	function automatic reply_t resolve_word(logic op, in_fields_t f);
		reply_t     r;
		logic [7:0] slot;
		logic       for_us;
		r.act    = ACT_NONE;
		r.fields = '0;
		if (op == OP_SEND) begin
			slot = f.target_ip[7:0];
			if (slot < TABLE_ENTRIES && learned[slot]) begin
				r.act                   = ACT_DATA;
				r.fields.out_dest_mac   = learned_mac[slot];
				r.fields.out_frame_type = ETYPE_IPV4;
			end else begin
				r.act                   = ACT_REQUEST;
				r.fields.out_dest_mac   = BCAST_MAC;
				r.fields.out_frame_type = ETYPE_ARP;
				r.fields.out_arp_opcode = ARP_REQ;
				r.fields.out_target_mac = BCAST_MAC;
				r.fields.out_target_ip  = f.target_ip;
			end
		end else if (f.frame_type == ETYPE_ARP) begin
			if (f.hw_type == HW_ETHERNET && f.proto_type == ETYPE_IPV4) begin
				for_us = (f.target_ip == own_ip);
				slot   = f.sender_ip[7:0];
				if (slot < TABLE_ENTRIES && (learned[slot] || for_us)) begin
					learned_mac[slot] = f.sender_mac;
					learned[slot]     = 1'b1;
				end
				if (for_us && f.arp_opcode == ARP_REQ) begin
					r.act                   = ACT_REPLY;
					r.fields.out_dest_mac   = f.sender_mac;
					r.fields.out_frame_type = ETYPE_ARP;
					r.fields.out_arp_opcode = ARP_REP;
					r.fields.out_target_mac = f.sender_mac;
					r.fields.out_target_ip  = f.sender_ip;
				end
			end
		end else if (f.dest_mac == own_mac) begin
			r.act = ACT_DELIVER;
		end
		return r;
	endfunction

	task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : watch
		reply_t      want;
		out_fields_t got;
		if (!arst_n) begin
			own_mac = '0;
			own_ip  = '0;
			foreach (learned[i])
				learned[i] = 1'b0;
			replies_due.delete();
		end else begin
			if (cfg_wen) begin
				case (cfg_idx)
					REG_MY_MAC: own_mac = cfg_wdata;
					REG_MY_IP:  own_ip  = cfg_wdata[31:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (replies_due.size() == 0) begin
					mismatches++;
					$display("%0t ns: unexpected result word, action %0d", $time, m_tuser);
				end else begin
					want = replies_due.pop_front();
					check_field("action", 48'(want.act), 48'(m_tuser));
					check_field("out_dest_mac", want.fields.out_dest_mac, got.out_dest_mac);
					check_field("out_frame_type", 48'(want.fields.out_frame_type),
						48'(got.out_frame_type));
					check_field("out_arp_opcode", 48'(want.fields.out_arp_opcode),
						48'(got.out_arp_opcode));
					check_field("out_target_mac", want.fields.out_target_mac,
						got.out_target_mac);
					check_field("out_target_ip", 48'(want.fields.out_target_ip),
						48'(got.out_target_ip));
				end
			end
			if (s_tvalid && s_tready)
				replies_due.push_back(resolve_word(s_tuser, s_tdata));
		end
		replies_owed = replies_due.size();
	end

endmodule

// File: tb/arp_resolver_table_test.sv
`timescale 1ns / 1ps

module arp_resolver_table_test;

	import arpr_pkg::*;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    s_tvalid  = 1'b0;
	logic                    s_tready;
	logic [IN_TDATA_W-1:0]   s_tdata   = '0;
	logic                    s_tuser   = 1'b0;
	logic                    m_tvalid;
	logic                    m_tready  = 1'b1;
	logic [OUT_TDATA_W-1:0]  m_tdata;
	logic [2:0]              m_tuser;
	logic                    cfg_wen   = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_idx   = REG_MY_MAC;
	logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

	int          mismatches;
	int          replies_owed;
	int          words_sent = 0;
	bit          quiet      = 1'b0;
	logic [47:0] cur_mac    = '0;
	logic [31:0] cur_ip     = '0;

	always #2 clk = ~clk;

	arp_resolver_table DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	arp_resolver_table_checker arp_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.cfg_wen      (cfg_wen),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.mismatches   (mismatches),
		.replies_owed (replies_owed)
	);

	function automatic logic [47:0] any_mac();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// Most addresses land in a few low slots so that the table actually gets hit.
	function automatic logic [31:0] neighbor_ip();
		logic [7:0] slot;
		slot = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
		return {24'($urandom), slot};
	endfunction

	function automatic in_fields_t noise_word();
		in_fields_t f;
		f.target_ip  = $urandom;
		f.frame_type = 16'($urandom);
		f.dest_mac   = any_mac();
		f.hw_type    = 16'($urandom);
		f.proto_type = 16'($urandom);
		f.arp_opcode = 16'($urandom);
		f.sender_mac = any_mac();
		f.sender_ip  = $urandom;
		return f;
	endfunction

	function automatic in_fields_t lookup_word(logic [31:0] ip);
		in_fields_t f;
		f           = noise_word();
		f.target_ip = ip;
		return f;
	endfunction

	function automatic in_fields_t arp_word(logic [31:0] tip, logic [15:0] opc,
			logic [47:0] smac, logic [31:0] sip);
		in_fields_t f;
		f.target_ip  = tip;
		f.frame_type = ETYPE_ARP;
		f.dest_mac   = BCAST_MAC;
		f.hw_type    = HW_ETHERNET;
		f.proto_type = ETYPE_IPV4;
		f.arp_opcode = opc;
		f.sender_mac = smac;
		f.sender_ip  = sip;
		return f;
	endfunction

	function automatic in_fields_t frame_word(logic [15:0] ftype, logic [47:0] dmac);
		in_fields_t f;
		f            = noise_word();
		f.frame_type = ftype;
		f.dest_mac   = dmac;
		return f;
	endfunction

	task automatic send_word(logic op, in_fields_t f);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= f;
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (replies_owed == 0);
	endtask

	task automatic set_addresses(logic [47:0] mac, logic [31:0] ip);
		drain();
		cfg_wen   <= 1'b1;
		cfg_idx   <= REG_MY_MAC;
		cfg_wdata <= mac;
		@(posedge clk);
		cfg_idx   <= REG_MY_IP;
		cfg_wdata <= 48'(ip);
		@(posedge clk);
		cfg_wen <= 1'b0;
		cur_mac = mac;
		cur_ip  = ip;
	endtask

	task automatic random_word(output logic op, output in_fields_t f);
		int kind;
		kind = $urandom_range(0, 9);
		f    = noise_word();
		op   = OP_RECEIVE;
		if (kind <= 2) begin
			op          = OP_SEND;
			f.target_ip = neighbor_ip();
		end else if (kind <= 6) begin
			f = arp_word(($urandom_range(0, 4) < 3) ? cur_ip : neighbor_ip(),
				$urandom_range(0, 1) ? ARP_REQ : ARP_REP, any_mac(), neighbor_ip());
			if ($urandom_range(0, 4) == 0)
				f.arp_opcode = 16'($urandom);
			if ($urandom_range(0, 2) == 0)
				f.dest_mac = $urandom_range(0, 1) ? cur_mac : any_mac();
		end else if (kind == 7) begin
			if ($urandom_range(0, 1))
				f.dest_mac = cur_mac;
		end else if (kind == 8) begin
			f = arp_word(cur_ip, ARP_REQ, any_mac(), neighbor_ip());
			if ($urandom_range(0, 1))
				f.hw_type ^= 16'(1 << $urandom_range(0, 15));
			else
				f.proto_type ^= 16'(1 << $urandom_range(0, 15));
		end else begin
			op = 1'($urandom);
		end
	endtask

	initial begin : stimulus
		logic        op;
		in_fields_t  f;
		logic [31:0] my_ip;
		my_ip = 32'hC0A8_0001;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(OP_RECEIVE, frame_word(ETYPE_IPV4, 48'h0));
		set_addresses(48'h0200_5E10_2030, my_ip);
		send_word(OP_SEND, lookup_word(32'hC0A8_0005));
		send_word(OP_RECEIVE, arp_word(my_ip, ARP_REQ, 48'h0A11_2233_4455, 32'hC0A8_0005));
		send_word(OP_SEND, lookup_word(32'hC0A8_0005));
		send_word(OP_RECEIVE, arp_word(32'hC0A8_0009, ARP_REQ, 48'h0A66_7788_99AA,
			32'hC0A8_0005));
		send_word(OP_SEND, lookup_word(32'hC0A8_0005));
		send_word(OP_RECEIVE, arp_word(32'hC0A8_0009, ARP_REQ, 48'h0ABB_CCDD_EEFF,
			32'hC0A8_0007));
		send_word(OP_SEND, lookup_word(32'hC0A8_0007));
		send_word(OP_RECEIVE, arp_word(my_ip, ARP_REP, 48'h0A12_3456_789A, 32'hC0A8_0007));
		send_word(OP_SEND, lookup_word(32'hC0A8_0007));
		f = arp_word(my_ip, ARP_REQ, 48'h0A00_0000_0011, 32'hC0A8_0011);
		f.hw_type = 16'h0006;
		send_word(OP_RECEIVE, f);
		f = arp_word(my_ip, ARP_REQ, 48'h0A00_0000_0012, 32'hC0A8_0012);
		f.proto_type = 16'h86DD;
		send_word(OP_RECEIVE, f);
		send_word(OP_SEND, lookup_word(32'hC0A8_0011));
		send_word(OP_SEND, lookup_word(32'hFFFF_FFFF));
		send_word(OP_RECEIVE, arp_word(my_ip, ARP_REQ, BCAST_MAC, 32'hFFFF_FFFF));
		send_word(OP_SEND, lookup_word(32'hFFFF_FFFF));
		send_word(OP_RECEIVE, arp_word(my_ip, ARP_REQ, 48'h0, 32'h0));
		send_word(OP_SEND, lookup_word(32'h0));
		send_word(OP_RECEIVE, frame_word(ETYPE_IPV4, cur_mac));
		send_word(OP_RECEIVE, frame_word(16'hFFFF, cur_mac));
		send_word(OP_RECEIVE, frame_word(ETYPE_IPV4, BCAST_MAC));
		send_word(OP_RECEIVE, arp_word(my_ip, 16'h0003, 48'h0A00_0000_0009, 32'hC0A8_0009));
		send_word(OP_SEND, lookup_word(32'hC0A8_0009));
		f = arp_word(32'hC0A8_0042, ARP_REQ, 48'h0A00_0000_0013, 32'hC0A8_0013);
		f.dest_mac = cur_mac;
		send_word(OP_RECEIVE, f);

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0:       set_addresses('1, '1);
				1:       set_addresses('0, '0);
				default: set_addresses(any_mac(), $urandom);
			endcase
			quiet = (phase == 4);
			repeat (200) begin
				random_word(op, f);
				send_word(op, f);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && replies_owed == 0)
			$display("arp_resolver_table: match");
		else
			$display("arp_resolver_table: mismatch");
		$finish;
	end

	initial begin : receiver
		int  gap;
		bit  held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!held && words_sent >= 60) begin
				// A long hold-off so that the block fills up and stops taking words.
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (60) @(posedge clk);
				m_tready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 4);
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		#1_000_000;
		$display("arp_resolver_table: mismatch");
		$finish;
	end

endmodule

// File: arp_resolver_table.f
rtl/core/arpr_pkg.sv
rtl/core/arpr_table.sv
rtl/core/arp_resolver_table.sv
rtl/core/arpr_checker.sv
tb/arp_resolver_table_checker.sv
tb/arp_resolver_table_test.sv
